[rtl/core/frt_pkg.sv]
// Package for the frame reassembly tracker: transaction types, action,
// result and status codes, and fixed constants. No dependencies.
package frt_pkg;

   // Action codes of an input transaction.
   localparam logic [1:0] ACT_HEADER  = 2'd0;
   localparam logic [1:0] ACT_PAYLOAD = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER    = 2'd0;
   localparam logic [1:0] KIND_FRAME_END = 2'd1;
   localparam logic [1:0] KIND_READ      = 2'd2;

   // Status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_ADDR  = 3'd1;
   localparam logic [2:0] ST_STALE     = 3'd2;
   localparam logic [2:0] ST_BAD_SEQ   = 3'd3;
   localparam logic [2:0] ST_BAD_LEN   = 3'd4;

   localparam logic [15:0] TAG_VALUE        = 16'h34CD;
   localparam logic [12:0] FRAME_SIZE_RESET = 13'd1500;
   localparam int          FS_W             = 13;
   localparam int          REM_W            = 14;
   localparam int          PROD_W           = 26;

   typedef struct packed {
      logic [1:0]  action;
      logic [47:0] packet_id;
      logic [47:0] length_and_tag;
      logic [47:0] third_address;
      logic [11:0] frame_sequence;
      logic [7:0]  payload_byte;
      logic        last_byte;
      logic [15:0] read_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  status;
      logic        packet_complete;
      logic [31:0] lost_total;
      logic [16:0] packet_length;
      logic [7:0]  read_data;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take;
      logic       div_start;
      logic       div_step;
      logic       commit;
      logic       mul;
      logic       finish;
      logic       respond;
      logic [1:0] rsp_kind;
      logic [2:0] rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] action;
      logic       bad_addr;
      logic       stale;
      logic       newer;
      logic       len_bad;
      logic       pay_end;
      logic       rd_ok;
      logic       div_last;
      logic       total_bad;
      logic       seq_bad;
      logic       rsp_busy;
   } stat_type;

endpackage

[rtl/core/frt_ctrl.sv]
// Controller state machine of the frame reassembly tracker.
// Depends on frt_pkg for the command and status structs and codes.
module frt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  frt_pkg::stat_type stat,
   output frt_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIV    = 3'd1;
   localparam logic [2:0] S_COMMIT = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;
   localparam logic [2:0] S_LENBAD = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       take;

   // Items enter only in idle and only when the result slot is free.
   assign req_stall = (state_ff != S_IDLE) || stat.rsp_busy;
   assign take      = req_valid && !req_stall;

   // Next state and command decode.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.take       = take;
      cmd.rsp_kind   = frt_pkg::KIND_HEADER;
      cmd.rsp_status = frt_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               unique case (stat.action)
                  frt_pkg::ACT_HEADER: begin
                     if (stat.bad_addr) begin
                        cmd.respond    = 1'b1;
                        cmd.rsp_status = frt_pkg::ST_BAD_ADDR;
                     end else if (stat.stale) begin
                        cmd.respond    = 1'b1;
                        cmd.rsp_status = frt_pkg::ST_STALE;
                     end else if (stat.newer && stat.len_bad) begin
                        cmd.respond    = 1'b1;
                        cmd.rsp_status = frt_pkg::ST_BAD_LEN;
                     end else if (stat.newer) begin
                        cmd.div_start = 1'b1;
                        state_in      = S_DIV;
                     end else begin
                        state_in = S_MUL;
                     end
                  end
                  frt_pkg::ACT_PAYLOAD: begin
                     if (stat.pay_end) begin
                        cmd.respond  = 1'b1;
                        cmd.rsp_kind = frt_pkg::KIND_FRAME_END;
                     end
                  end
                  frt_pkg::ACT_READ: begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_kind   = frt_pkg::KIND_READ;
                     cmd.rsp_status = stat.rd_ok ? frt_pkg::ST_OK : frt_pkg::ST_BAD_LEN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.total_bad) begin
               state_in = S_LENBAD;
            end else begin
               cmd.commit = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!stat.rsp_busy) begin
               cmd.finish     = 1'b1;
               cmd.respond    = 1'b1;
               cmd.rsp_status = stat.seq_bad ? frt_pkg::ST_BAD_SEQ : frt_pkg::ST_OK;
               state_in       = S_IDLE;
            end
         end
         S_LENBAD: begin
            if (!stat.rsp_busy) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = frt_pkg::ST_BAD_LEN;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/frt_datapath.sv]
// Datapath of the frame reassembly tracker: packet state, frame map,
// frame-count divider, offset multipliers, packet buffer and result register.
// Depends on frt_pkg.
module frt_datapath #(
   parameter int MAX_PACKET_BYTES = 65536,
   parameter int MAX_FRAMES       = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [12:0]       csr_write_data,
   input  frt_pkg::req_type  req_payload,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output frt_pkg::rsp_type  rsp_payload,
   input  frt_pkg::cmd_type  cmd,
   output frt_pkg::stat_type stat
);

   localparam int LEN_W  = $clog2(MAX_PACKET_BYTES + 1);
   localparam int MEM_AW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
   localparam int DIV_W  = ((LEN_W > frt_pkg::FS_W) ? LEN_W : frt_pkg::FS_W) + 1;
   localparam int CNT_W  = $clog2(DIV_W + 1);
   localparam int FT_W   = $clog2(MAX_FRAMES + 1);
   localparam int FI_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int PW     = frt_pkg::PROD_W;
   localparam int REM_W_L = frt_pkg::REM_W;

   // Configuration and packet state.
   logic [12:0]           fs_ff;
   logic [12:0]           fs_eff;
   logic [47:0]           cur_ff;
   logic [31:0]           lost_ff;
   logic [LEN_W-1:0]      len_held_ff;
   logic [FT_W-1:0]       ftotal_ff;
   logic [FT_W-1:0]       fseen_ff;
   logic [MAX_FRAMES-1:0] fvalid_ff;
   logic                  done_ff;
   logic                  open_ff;
   logic [LEN_W-1:0]      wp_ff;
   logic [LEN_W-1:0]      lim_ff;

   // Captured header fields.
   logic [47:0]      pn_ff;
   logic [LEN_W-1:0] len_ff;
   logic [11:0]      seq_ff;
   logic [47:0]      gap_ff;

   // Divider and multiplier registers.
   logic [DIV_W-1:0] quo_ff;
   logic [REM_W_L-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [PW-1:0]    pwp_ff;
   logic [PW-1:0]    plim_ff;

   // Result register and buffer.
   logic             rsp_valid_ff;
   logic [1:0]       rkind_ff;
   logic [2:0]       rstat_ff;
   logic             rcomp_ff;
   logic [31:0]      rlost_ff;
   logic [16:0]      rlen_ff;
   logic             rdok_ff;
   logic [7:0]       rdq_ff;
   logic [7:0]       mem [MAX_PACKET_BYTES];

   logic             is_hdr;
   logic             is_pay;
   logic             is_rd;
   logic             rd_ok;
   logic             wr_en;
   logic [REM_W_L:0] div_r;
   logic             div_ge;
   logic [48:0]      lost_sum;
   logic [FI_W-1:0]  fidx;
   logic             pulse;
   logic [FT_W-1:0]  seen_next;
   logic [PW-1:0]    lim_clamp;
   logic [31:0]      len_in;

   assign fs_eff = (fs_ff == '0) ? 13'd1 : fs_ff;
   assign is_hdr = cmd.take && (req_payload.action == frt_pkg::ACT_HEADER);
   assign is_pay = cmd.take && (req_payload.action == frt_pkg::ACT_PAYLOAD);
   assign is_rd  = cmd.take && (req_payload.action == frt_pkg::ACT_READ);
   assign len_in = req_payload.length_and_tag[31:0];
   assign rd_ok  = (32'(req_payload.read_offset) < 32'(len_held_ff))
                && (32'(req_payload.read_offset) < 32'(MAX_PACKET_BYTES));
   assign wr_en  = is_pay && open_ff && (wp_ff < lim_ff)
                && (32'(wp_ff) < 32'(MAX_PACKET_BYTES));

   // Status toward the controller.
   always_comb begin
      stat.action    = req_payload.action;
      stat.bad_addr  = (req_payload.third_address != '1)
                    || (req_payload.length_and_tag[47:32] != frt_pkg::TAG_VALUE);
      stat.stale     = req_payload.packet_id < cur_ff;
      stat.newer     = req_payload.packet_id > cur_ff;
      stat.len_bad   = (len_in == '0) || (len_in > 32'(MAX_PACKET_BYTES));
      stat.pay_end   = open_ff && req_payload.last_byte;
      stat.rd_ok     = rd_ok;
      stat.div_last  = cnt_ff == CNT_W'(DIV_W - 1);
      stat.total_bad = quo_ff > DIV_W'(MAX_FRAMES);
      stat.seq_bad   = 16'(seq_ff) >= 16'(ftotal_ff);
      stat.rsp_busy  = rsp_valid_ff && rsp_stall;
   end

   // One restoring divider step: remainder times two plus next dividend bit.
   assign div_r  = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge = div_r >= (REM_W_L + 1)'(fs_eff);

   assign lost_sum  = {17'd0, lost_ff} + {1'b0, gap_ff};
   assign fidx      = FI_W'(seq_ff);
   assign seen_next = fvalid_ff[fidx] ? fseen_ff : fseen_ff + FT_W'(1);
   assign pulse     = (seen_next == ftotal_ff) && !done_ff;
   assign lim_clamp = (plim_ff > PW'(len_held_ff)) ? PW'(len_held_ff) : plim_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff        <= frt_pkg::FRAME_SIZE_RESET;
         cur_ff       <= '0;
         lost_ff      <= '0;
         len_held_ff  <= '0;
         ftotal_ff    <= '0;
         fseen_ff     <= '0;
         fvalid_ff    <= '0;
         done_ff      <= 1'b0;
         open_ff      <= 1'b0;
         wp_ff        <= '0;
         lim_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            fs_ff <= csr_write_data;
         end
         // Any header closes the open frame; a final byte closes it too.
         if (is_hdr || (is_pay && req_payload.last_byte)) begin
            open_ff <= 1'b0;
         end
         if (wr_en) begin
            wp_ff <= wp_ff + LEN_W'(1);
         end
         if (cmd.div_start) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         // Start of a new packet.
         if (cmd.commit) begin
            lost_ff     <= (lost_sum[48:32] != '0) ? '1 : lost_sum[31:0];
            cur_ff      <= pn_ff;
            len_held_ff <= len_ff;
            ftotal_ff   <= FT_W'(quo_ff);
            fseen_ff    <= '0;
            fvalid_ff   <= '0;
            done_ff     <= 1'b0;
         end
         // Frame header accepted: mark the frame and open it for writing.
         if (cmd.finish && !stat.seq_bad) begin
            fvalid_ff[fidx] <= 1'b1;
            fseen_ff        <= seen_next;
            done_ff         <= seen_next == ftotal_ff;
            wp_ff           <= LEN_W'(pwp_ff);
            lim_ff          <= LEN_W'(lim_clamp);
            open_ff         <= 1'b1;
         end
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Header capture, divider and multipliers.
   always_ff @(posedge clock) begin
      if (is_hdr) begin
         pn_ff  <= req_payload.packet_id;
         len_ff <= LEN_W'(len_in);
         seq_ff <= req_payload.frame_sequence;
         gap_ff <= req_payload.packet_id - cur_ff - 48'd1;
      end
      if (cmd.div_start) begin
         quo_ff <= DIV_W'(LEN_W'(len_in)) + DIV_W'(fs_eff) - DIV_W'(1);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[DIV_W-2:0], div_ge};
         rem_ff <= div_ge ? REM_W_L'(div_r - (REM_W_L + 1)'(fs_eff)) : div_r[REM_W_L-1:0];
      end
      if (cmd.mul) begin
         pwp_ff  <= PW'(seq_ff) * PW'(fs_eff);
         plim_ff <= (PW'(seq_ff) + PW'(1)) * PW'(fs_eff);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rkind_ff <= cmd.rsp_kind;
         rstat_ff <= cmd.rsp_status;
         rcomp_ff <= cmd.finish && !stat.seq_bad && pulse;
         rlost_ff <= cmd.commit ? lost_ff : lost_ff;
         rlen_ff  <= 17'(len_held_ff);
         rdok_ff  <= is_rd && rd_ok;
      end
   end

   // Packet buffer.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[MEM_AW'(wp_ff)] <= req_payload.payload_byte;
      end
      if (is_rd) begin
         rdq_ff <= mem[MEM_AW'(req_payload.read_offset)];
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_payload.result_kind     = rkind_ff;
   assign rsp_payload.status          = rstat_ff;
   assign rsp_payload.packet_complete = rcomp_ff;
   assign rsp_payload.lost_total      = rlost_ff;
   assign rsp_payload.packet_length   = rlen_ff;
   assign rsp_payload.read_data       = rdok_ff ? rdq_ff : 8'd0;

endmodule

[rtl/core/frame_reassembly_tracker.sv]
// Top level of the frame reassembly tracker.
// Instantiates frt_ctrl and frt_datapath; depends on frt_pkg.
//
// Usage:
//   The req channel carries one transaction per item: a frame header, one
//   payload byte, or a read of a stored byte. The rsp channel returns at most
//   one result per item. csr_write_enable with csr_write_data sets the frame
//   size; write it only while the block is idle.
//   Payload bytes and reads can arrive back to back while the result slot is
//   not held by rsp_stall; a read result comes from the registered buffer port
//   on the next cycle. A header that is rejected at once (bad address, stale,
//   bad length) is answered from idle. A header for the current packet goes
//   through the multiply and finish states. A header that starts a new packet
//   adds the frame-count divider, one quotient bit per cycle over
//   max(LEN, 13)+1 steps for LEN = clog2(MAX_PACKET_BYTES+1), then a commit
//   state; a packet that needs too many frames is refused there.
//   Reset restores the frame size to 1500 and clears all packet state; the
//   buffer itself is not cleared and needs no clearing pass.
//   While the receiver holds rsp_stall on a valid result, the result stays in
//   its register and req_stall stays high, so no item is lost.
module frame_reassembly_tracker #(
   parameter int MAX_PACKET_BYTES = 65536,
   parameter int MAX_FRAMES       = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [12:0]      csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  frt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output frt_pkg::rsp_type rsp_payload
);

   frt_pkg::cmd_type  cmd;
   frt_pkg::stat_type stat;

   // Sequencer for header processing and result issue.
   frt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Packet state, arithmetic and buffer.
   frt_datapath #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .MAX_FRAMES       (MAX_FRAMES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

[tb/frame_reassembly_tracker_tb.sv]
// Self-checking testbench for frame_reassembly_tracker: directed and random frame traffic
// checked against a behavioral copy of the reassembly logic. Depends on frt_pkg and the RTL.
`timescale 1ns / 1ps
module frame_reassembly_tracker_tb;

   localparam int BUF_BYTES  = 65536;
   localparam int FRAME_MAX  = 64;
   localparam int QUIET_MAX  = 4000;
   localparam int HOLD_LEN   = 400;
   localparam logic [47:0] PN_TOP = 48'hFFFF_FFFF_FFFF;
   localparam logic [1:0] ACT_NONE = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_write_enable = 1'b0;
   logic [12:0] csr_write_data = '0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   frt_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   frt_pkg::rsp_type rsp_payload;

   frame_reassembly_tracker u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

   always #1 clock = ~clock;

   // Transactions waiting to be driven and results still owed by the block.
   frt_pkg::req_type pending_reqs[$];
   frt_pkg::rsp_type owed_results[$];
   int      issued_count = 0;
   int      taken_count = 0;
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_asked = 0;
   int      hold_served = 0;
   int      hold_left = 0;
   int      quiet_cycles = 0;

   // Shadow of the tracker state.
   logic [12:0] frame_size_reg = frt_pkg::FRAME_SIZE_RESET;
   logic [47:0] cur_pkt = '0;
   logic [31:0] lost_cnt = '0;
   int          len_held = 0;
   int          frm_total = 0;
   int          frm_seen = 0;
   bit          frm_valid [FRAME_MAX];
   bit          pkt_done = 0;
   bit          frm_open = 0;
   int          wr_ptr = 0;
   int          frm_limit = 0;
   logic [7:0]  pkt_bytes [BUF_BYTES];
   bit          byte_written [BUF_BYTES];

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic int eff_frame_size();
      return (frame_size_reg == 0) ? 1 : int'(frame_size_reg);
   endfunction

   // Apply one transaction to the shadow state and queue the result it causes.
   task automatic reassemble_step(input frt_pkg::req_type r);
      frt_pkg::rsp_type o;
      bit          has_rsp;
      bit          rejected;
      int          fs;
      logic [63:0] len;
      logic [63:0] tot;
      logic [63:0] sum;
      int          seq;
      bit          complete;
      o = '0;
      has_rsp = 0;
      rejected = 0;
      fs = eff_frame_size();
      seq = int'(r.frame_sequence);
      case (r.action)
         frt_pkg::ACT_HEADER: begin
            has_rsp = 1;
            o.result_kind = frt_pkg::KIND_HEADER;
            frm_open = 0;
            if (r.third_address != PN_TOP
                || r.length_and_tag[47:32] != frt_pkg::TAG_VALUE) begin
               o.status = frt_pkg::ST_BAD_ADDR;
            end else if (r.packet_id < cur_pkt) begin
               o.status = frt_pkg::ST_STALE;
            end else begin
               if (r.packet_id > cur_pkt) begin
                  len = {32'd0, r.length_and_tag[31:0]};
                  tot = (len + fs - 1) / fs;
                  if (len == 0 || len > BUF_BYTES || tot > FRAME_MAX) begin
                     o.status = frt_pkg::ST_BAD_LEN;
                     rejected = 1;
                  end else begin
                     sum = {32'd0, lost_cnt} + {16'd0, r.packet_id - cur_pkt - 48'd1};
                     lost_cnt = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                     cur_pkt = r.packet_id;
                     len_held = int'(len);
                     frm_total = int'(tot);
                     frm_seen = 0;
                     foreach (frm_valid[i]) frm_valid[i] = 0;
                     pkt_done = 0;
                  end
               end
               if (!rejected) begin
                  if (seq >= frm_total) begin
                     o.status = frt_pkg::ST_BAD_SEQ;
                  end else begin
                     if (!frm_valid[seq]) begin
                        frm_valid[seq] = 1;
                        frm_seen++;
                     end
                     wr_ptr = seq * fs;
                     frm_limit = (seq + 1) * fs;
                     if (frm_limit > len_held) frm_limit = len_held;
                     frm_open = 1;
                     complete = (frm_seen == frm_total);
                     o.packet_complete = complete && !pkt_done;
                     pkt_done = complete;
                     o.status = frt_pkg::ST_OK;
                  end
               end
            end
         end
         frt_pkg::ACT_PAYLOAD: begin
            if (frm_open) begin
               if (wr_ptr < frm_limit && wr_ptr < BUF_BYTES) begin
                  pkt_bytes[wr_ptr] = r.payload_byte;
                  byte_written[wr_ptr] = 1;
                  wr_ptr++;
               end
               if (r.last_byte) begin
                  frm_open = 0;
                  has_rsp = 1;
                  o.result_kind = frt_pkg::KIND_FRAME_END;
                  o.status = frt_pkg::ST_OK;
               end
            end
         end
         frt_pkg::ACT_READ: begin
            has_rsp = 1;
            o.result_kind = frt_pkg::KIND_READ;
            if (int'(r.read_offset) < len_held) begin
               o.status = frt_pkg::ST_OK;
               o.read_data = pkt_bytes[r.read_offset];
            end else begin
               o.status = frt_pkg::ST_BAD_LEN;
            end
         end
         default: ;
      endcase
      o.lost_total = lost_cnt;
      o.packet_length = len_held[16:0];
      if (has_rsp) owed_results.push_back(o);
   endtask

   task automatic issue(input frt_pkg::req_type r);
      reassemble_step(r);
      pending_reqs.push_back(r);
      issued_count++;
   endtask

   function automatic logic [47:0] rand48();
      logic [31:0] lo;
      logic [31:0] hi;
      lo = $urandom;
      hi = $urandom;
      return {hi[15:0], lo};
   endfunction

   function automatic frt_pkg::req_type rand_req();
      frt_pkg::req_type r;
      logic [31:0] w;
      w = $urandom;
      r.action = w[1:0];
      r.packet_id = rand48();
      r.length_and_tag = rand48();
      r.third_address = rand48();
      r.frame_sequence = w[13:2];
      r.payload_byte = w[21:14];
      r.last_byte = w[22];
      r.read_offset = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   function automatic frt_pkg::req_type mk_header(input logic [47:0] pn,
                                                  input logic [31:0] len, input int seq);
      frt_pkg::req_type r;
      r = rand_req();
      r.action = frt_pkg::ACT_HEADER;
      r.packet_id = pn;
      r.length_and_tag = {frt_pkg::TAG_VALUE, len};
      r.third_address = PN_TOP;
      r.frame_sequence = seq[11:0];
      return r;
   endfunction

   function automatic frt_pkg::req_type mk_byte(input logic [7:0] b, input bit last);
      frt_pkg::req_type r;
      r = rand_req();
      r.action = frt_pkg::ACT_PAYLOAD;
      r.payload_byte = b;
      r.last_byte = last;
      return r;
   endfunction

   // A read aims at a stored byte or past the packet end (else no action), never at an unwritten byte.
   task automatic issue_read();
      frt_pkg::req_type r;
      int      off;
      bit      found;
      r = rand_req();
      r.action = frt_pkg::ACT_READ;
      found = 0;
      if (len_held > 0 && $urandom_range(2) != 0) begin
         for (int k = 0; k < 12 && !found; k++) begin
            off = $urandom_range(0, len_held - 1);
            if (byte_written[off]) found = 1;
         end
      end
      if (found) begin
         r.read_offset = off[15:0];
      end else if (len_held < BUF_BYTES) begin
         r.read_offset = 16'($urandom_range(len_held, 65535));
      end else begin
         r.action = ACT_NONE;
      end
      issue(r);
   endtask

   // Malformed or unusual traffic mixed between frames.
   task automatic issue_noise();
      frt_pkg::req_type r;
      logic [31:0] len;
      int          fs;
      fs = eff_frame_size();
      r = mk_header(cur_pkt, $urandom, $urandom_range(0, 4095));
      case ($urandom_range(0, 8))
         0: r.length_and_tag[47:32] = frt_pkg::TAG_VALUE ^ 16'($urandom_range(1, 65535));
         1: r.third_address = rand48() & ~(48'd1 << $urandom_range(0, 47));
         2: if (cur_pkt > 0) r.packet_id = rand48() % cur_pkt;
         3: begin
            if (cur_pkt != PN_TOP) r.packet_id = cur_pkt + 1 + $urandom_range(0, 3);
            case ($urandom_range(0, 2))
               0: len = 0;
               1: len = 32'(BUF_BYTES + 1) + ($urandom % 32'hFFFE_0000);
               default: len = (65 * fs <= BUF_BYTES) ? 32'(65 * fs) : $urandom | 32'h0002_0000;
            endcase
            r.length_and_tag[31:0] = len;
         end
         4: r.frame_sequence = 12'($urandom_range(frm_total, 4095));
         5: begin
            if (cur_pkt != PN_TOP) r.packet_id = cur_pkt + 1;
            r.length_and_tag[31:0] = $urandom_range(1, 64);
            r.frame_sequence = 12'($urandom_range(64, 4095));
         end
         6: r = mk_byte(8'($urandom), 1'($urandom));
         7: r.action = ACT_NONE;
         default: begin
            issue_read();
            return;
         end
      endcase
      issue(r);
   endtask

   // One packet: its frames in random order, some dropped or repeated, some cut short.
   task automatic issue_packet(input int pn_mode);
      logic [47:0] pn;
      logic [47:0] step;
      int          fs;
      int          maxlen;
      int          len;
      int          tot;
      int          order[$];
      int          tmp;
      int          j;
      int          nb;
      fs = eff_frame_size();
      maxlen = (FRAME_MAX * fs > BUF_BYTES) ? BUF_BYTES : FRAME_MAX * fs;
      if ($urandom_range(9) == 0) len = $urandom_range(1, maxlen);
      else len = $urandom_range(1, (maxlen < 300) ? maxlen : 300);
      case (pn_mode)
         1: step = ($urandom_range(15) == 0) ? {16'd0, 32'($urandom)} + 1
                                             : 48'($urandom_range(1, 3));
         2: step = (cur_pkt < PN_TOP - 48'h100) ? PN_TOP - 48'h100 - cur_pkt
                                                : 48'($urandom_range(1, 3));
         default: step = 48'($urandom_range(1, 3));
      endcase
      if (PN_TOP - cur_pkt < step) begin
         pn = cur_pkt;
         len = len_held;
         tot = frm_total;
      end else begin
         pn = cur_pkt + step;
         tot = (len + fs - 1) / fs;
      end
      for (int i = 0; i < tot; i++) order.push_back(i);
      for (int i = tot - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      if (tot > 1 && $urandom_range(7) == 0) void'(order.pop_back());
      if (tot > 0 && $urandom_range(9) == 0) order.push_back(order[0]);
      foreach (order[i]) begin
         issue(mk_header(pn, len, order[i]));
         if (frm_open) begin
            nb = frm_limit - wr_ptr;
            // Packets with many frames get only a few bytes per frame.
            if (tot > 8 && nb > 4) nb = $urandom_range(1, 4);
            else if (nb > 40) nb = $urandom_range(1, 40);
            if (nb < 1) nb = 1;
            if ($urandom_range(7) == 0) nb += $urandom_range(1, 2);
            for (int k = 0; k < nb; k++)
               issue(mk_byte(8'($urandom), (k == nb - 1) && ($urandom_range(19) != 0)));
         end
         if ($urandom_range(3) == 0) issue_noise();
         if ($urandom_range(3) == 0) issue_read();
      end
   endtask

   task automatic wait_idle();
      while (taken_count != issued_count || owed_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_frame_size(input logic [12:0] v);
      repeat (30) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      frame_size_reg = v;
   endtask

   // Driver: offers the next pending transaction, holding it while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) taken_count++;
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result against the oldest owed one and drives the stall.
   always @(posedge clock) begin
      frt_pkg::rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result with nothing outstanding");
            end else begin
               e = owed_results.pop_front();
               if (rsp_payload.result_kind !== e.result_kind)
                  report_mismatch($sformatf("result_kind %0d, want %0d",
                                            rsp_payload.result_kind, e.result_kind));
               if (rsp_payload.status !== e.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_payload.status, e.status));
               if (rsp_payload.packet_complete !== e.packet_complete)
                  report_mismatch($sformatf("packet_complete %0d, want %0d",
                                            rsp_payload.packet_complete, e.packet_complete));
               if (rsp_payload.lost_total !== e.lost_total)
                  report_mismatch($sformatf("lost_total %0d, want %0d",
                                            rsp_payload.lost_total, e.lost_total));
               if (rsp_payload.packet_length !== e.packet_length)
                  report_mismatch($sformatf("packet_length %0d, want %0d",
                                            rsp_payload.packet_length, e.packet_length));
               if (rsp_payload.read_data !== e.read_data)
                  report_mismatch($sformatf("read_data %0h, want %0h",
                                            rsp_payload.read_data, e.read_data));
            end
         end
         // A requested hold keeps the receiver stalled for a long stretch.
         if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
         // Watchdog on cycles with no transaction on either side.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles > QUIET_MAX) begin
            $display("frame_reassembly_tracker test failed");
            $finish;
         end
      end
   end

   initial begin
      logic [12:0] sizes [7] = '{13'd1500, 13'd1, 13'd37, 13'd4096, 13'd0, 13'd8191, 13'd5};
      int          phase_start;
      foreach (frm_valid[i]) frm_valid[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset frame size.
      send_idle_pct = 9;
      recv_idle_pct = 83;
      begin
         frt_pkg::req_type r;
         r = rand_req(); r.action = frt_pkg::ACT_READ; r.read_offset = 16'd0; issue(r);
         issue(mk_byte(8'hFF, 1'b1));
         r = rand_req(); r.action = ACT_NONE; issue(r);
         r = mk_header(48'd1, 32'd100, 0); r.third_address = 48'hFFFF_FFFF_FFFE; issue(r);
         r = mk_header(48'd1, 32'd100, 0); r.length_and_tag[47:32] = 16'hCD34; issue(r);
         issue(mk_header(48'd0, 32'd100, 0));
         issue(mk_header(48'd1, 32'd0, 0));
         issue(mk_header(48'd1, 32'd65537, 0));
         issue(mk_header(48'd1, 32'hFFFF_FFFF, 0));
         issue(mk_header(48'd1, 32'd1503, 1));
         issue(mk_byte(8'h00, 1'b0));
         issue(mk_byte(8'hFF, 1'b0));
         issue(mk_byte(8'h5A, 1'b0));
         issue(mk_byte(8'hA5, 1'b1));
         issue(mk_header(48'd1, 32'd1503, 1));
         issue(mk_header(48'd1, 32'd1503, 0));
         issue(mk_byte(8'h81, 1'b1));
         issue(mk_header(48'd1, 32'd1503, 2));
         r = rand_req(); r.action = frt_pkg::ACT_READ; r.read_offset = 16'd1501; issue(r);
         r = rand_req(); r.action = frt_pkg::ACT_READ; r.read_offset = 16'd1503; issue(r);
         issue(mk_header(48'd5, 32'd65536, 43));
         issue(mk_byte(8'h3C, 1'b1));
         r = rand_req(); r.action = frt_pkg::ACT_READ; r.read_offset = 16'd64500; issue(r);
         issue(mk_header(48'd2, 32'd10, 0));
      end
      wait_idle();

      // Random phases, one frame size each.
      for (int p = 0; p < 7; p++) begin
         if (p != 0) write_frame_size(sizes[p]);
         send_idle_pct = (p < 3) ? 9 : (p < 5) ? 83 : 0;
         recv_idle_pct = (p < 3) ? 83 : (p < 5) ? 9 : 0;
         if (p == 5) hold_asked++;
         phase_start = issued_count;
         if (p == 6) issue_packet(2);
         while (issued_count - phase_start < 180) begin
            issue_packet((p >= 3) ? 1 : 0);
            if ($urandom_range(2) == 0) issue_noise();
         end
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("frame_reassembly_tracker test passed");
      end else begin
         $display("frame_reassembly_tracker test failed");
      end
      $finish;
   end

endmodule
